@@ design/point_to_line_distance_gate_macros.svh @@
// Assertion macros for the point-to-line distance gate.
// Needs i_clk and i_rst_n in the including module's scope.
`ifndef POINT_TO_LINE_DISTANCE_GATE_MACROS_SVH
`define POINT_TO_LINE_DISTANCE_GATE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PTLD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PTLD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ptld_pkg.sv @@
// Shared widths, types, register codes and rounding helper for the
// point-to-line distance gate. No dependencies.
package ptld_pkg;

    localparam int CRD_W  = 20;          // point / line point coordinate
    localparam int OFF_W  = CRD_W + 1;   // point minus line point
    localparam int DIR_W  = 16;          // Q1.15 direction
    localparam int PRD_W  = OFF_W + DIR_W;
    localparam int DOT_W  = PRD_W + 2;   // sum of three products
    localparam int T_W    = 23;          // projection length, 1/16 mm
    localparam int TU_W   = T_W + DIR_W;
    localparam int ORT_W  = 24;          // orthogonal component
    localparam int SQ_W   = 2 * ORT_W;   // squared length
    localparam int ROOT_W = SQ_W / 2;
    localparam int DIST_W = 21;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 21;
    localparam int RND_SH = 15;

    localparam int PROJ_STAGES = 5;
    localparam int NORM_STAGES = 2;
    localparam int PIPE_LAT    = PROJ_STAGES + NORM_STAGES + ROOT_W + 1;

    localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
    localparam logic [DIR_W-1:0]  DIR_Z_RST = 16'h7FFF;

    localparam logic [IDX_W-1:0] REG_LINE_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_LINE_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_LINE_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIR_X  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIR_Y  = 3'd4;
    localparam logic [IDX_W-1:0] REG_DIR_Z  = 3'd5;
    localparam logic [IDX_W-1:0] REG_MAX    = 3'd6;

    typedef logic signed [CRD_W-1:0] t_coord;
    typedef logic signed [OFF_W-1:0] t_off;
    typedef logic signed [DIR_W-1:0] t_dirc;
    typedef logic signed [ORT_W-1:0] t_ort;
    typedef logic [SQ_W-1:0]         t_sq;
    typedef logic [ROOT_W-1:0]       t_root;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pnt;

    typedef struct packed {
        t_off x;
        t_off y;
        t_off z;
    } t_offv;

    typedef struct packed {
        t_dirc x;
        t_dirc y;
        t_dirc z;
    } t_dir;

    typedef struct packed {
        t_ort x;
        t_ort y;
        t_ort z;
    } t_ortv;

    // Round a Q15-scaled value to nearest, ties toward +inf.
    function automatic logic signed [T_W-1:0] rnd_q15(input logic signed [TU_W-1:0] v);
        logic signed [TU_W-1:0] s;
        s = v + $signed({{(TU_W-RND_SH){1'b0}}, 1'b1, {(RND_SH-1){1'b0}}});
        return s[RND_SH +: T_W];
    endfunction

endpackage

@@ design/ptld_proj.sv @@
// Offset, projection onto the direction and removal of that component.
// Five register stages. Depends on ptld_pkg.
module ptld_proj (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ptld_pkg::t_pnt  i_point,
    input  ptld_pkg::t_pnt  i_line,
    input  ptld_pkg::t_dir  i_dir,
    output logic            o_valid,
    output ptld_pkg::t_ortv o_orth
);

    localparam int OW = ptld_pkg::OFF_W;
    localparam int PW = ptld_pkg::PRD_W;
    localparam int DW = ptld_pkg::DOT_W;
    localparam int TW = ptld_pkg::T_W;
    localparam int UW = ptld_pkg::TU_W;
    localparam int RW = ptld_pkg::ORT_W;

    logic [ptld_pkg::PROJ_STAGES-1:0] r_vld;

    ptld_pkg::t_offv r_d1, r_d2, r_d3, r_d4;
    ptld_pkg::t_offv n_d1;

    logic signed [PW-1:0] r_mx, r_my, r_mz;
    logic signed [PW-1:0] n_mx, n_my, n_mz;
    logic signed [DW-1:0] n_dot;
    logic signed [TW-1:0] r_t;
    logic signed [UW-1:0] r_tux, r_tuy, r_tuz;
    logic signed [UW-1:0] n_tux, n_tuy, n_tuz;
    logic signed [TW-1:0] n_px, n_py, n_pz;
    ptld_pkg::t_ortv      r_o, n_o;

    // stage 1: offset from the line point
    assign n_d1.x = {i_point.x[ptld_pkg::CRD_W-1], i_point.x}
                  - {i_line.x[ptld_pkg::CRD_W-1], i_line.x};
    assign n_d1.y = {i_point.y[ptld_pkg::CRD_W-1], i_point.y}
                  - {i_line.y[ptld_pkg::CRD_W-1], i_line.y};
    assign n_d1.z = {i_point.z[ptld_pkg::CRD_W-1], i_point.z}
                  - {i_line.z[ptld_pkg::CRD_W-1], i_line.z};

    // stage 2: per-axis products with the direction
    assign n_mx = r_d1.x * i_dir.x;
    assign n_my = r_d1.y * i_dir.y;
    assign n_mz = r_d1.z * i_dir.z;

    // stage 3: dot product, rounded back to 1/16 mm
    assign n_dot = {{(DW-PW){r_mx[PW-1]}}, r_mx}
                 + {{(DW-PW){r_my[PW-1]}}, r_my}
                 + {{(DW-PW){r_mz[PW-1]}}, r_mz};

    // stage 4: projection vector, still Q15-scaled
    assign n_tux = r_t * i_dir.x;
    assign n_tuy = r_t * i_dir.y;
    assign n_tuz = r_t * i_dir.z;

    // stage 5: round and subtract
    assign n_px = ptld_pkg::rnd_q15(r_tux);
    assign n_py = ptld_pkg::rnd_q15(r_tuy);
    assign n_pz = ptld_pkg::rnd_q15(r_tuz);

    assign n_o.x = {{(RW-OW){r_d4.x[OW-1]}}, r_d4.x} - {{(RW-TW){n_px[TW-1]}}, n_px};
    assign n_o.y = {{(RW-OW){r_d4.y[OW-1]}}, r_d4.y} - {{(RW-TW){n_py[TW-1]}}, n_py};
    assign n_o.z = {{(RW-OW){r_d4.z[OW-1]}}, r_d4.z} - {{(RW-TW){n_pz[TW-1]}}, n_pz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ptld_pkg::PROJ_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1  <= n_d1;
        r_d2  <= r_d1;
        r_d3  <= r_d2;
        r_d4  <= r_d3;
        r_mx  <= n_mx;
        r_my  <= n_my;
        r_mz  <= n_mz;
        r_t   <= ptld_pkg::rnd_q15(n_dot);
        r_tux <= n_tux;
        r_tuy <= n_tuy;
        r_tuz <= n_tuz;
        r_o   <= n_o;
    end

    assign o_valid = r_vld[ptld_pkg::PROJ_STAGES-1];
    assign o_orth  = r_o;

endmodule

@@ design/ptld_norm.sv @@
// Squared length of the orthogonal vector: squares, then their sum.
// Two register stages. Depends on ptld_pkg.
module ptld_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ptld_pkg::t_ortv i_orth,
    output logic            o_valid,
    output ptld_pkg::t_sq   o_sq
);

    localparam int SW = ptld_pkg::SQ_W;

    logic [ptld_pkg::NORM_STAGES-1:0] r_vld;
    logic signed [SW-1:0] n_px, n_py, n_pz;
    ptld_pkg::t_sq        r_px, r_py, r_pz;
    ptld_pkg::t_sq        r_sum;

    assign n_px = i_orth.x * i_orth.x;
    assign n_py = i_orth.y * i_orth.y;
    assign n_pz = i_orth.z * i_orth.z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ptld_pkg::NORM_STAGES-2:0], i_valid};
        end
    end

    // squares are non-negative and their sum stays below 2^46
    always_ff @(posedge i_clk) begin
        r_px  <= $unsigned(n_px);
        r_py  <= $unsigned(n_py);
        r_pz  <= $unsigned(n_pz);
        r_sum <= r_px + r_py + r_pz;
    end

    assign o_valid = r_vld[ptld_pkg::NORM_STAGES-1];
    assign o_sq    = r_sum;

endmodule

@@ design/ptld_sqrt.sv @@
// Pipelined truncating square root, one result bit per register stage.
// Depends on ptld_pkg.
module ptld_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ptld_pkg::t_sq   i_sq,
    output logic            o_valid,
    output ptld_pkg::t_root o_root
);

    localparam int SW = ptld_pkg::SQ_W;
    localparam int RW = ptld_pkg::ROOT_W;

    logic          r_vld  [RW];
    ptld_pkg::t_root r_root [RW];
    ptld_pkg::t_sq   r_rem  [RW-1];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;

        logic            w_vin;
        ptld_pkg::t_sq   w_rin;
        ptld_pkg::t_root w_qin;
        logic [SW:0]     w_trial;
        logic            w_take;

        if (k == 0) begin : g_first
            assign w_vin = i_valid;
            assign w_rin = i_sq;
            assign w_qin = '0;
        end else begin : g_next
            assign w_vin = r_vld[k-1];
            assign w_rin = r_rem[k-1];
            assign w_qin = r_root[k-1];
        end

        // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
        assign w_trial = ({{(SW+1-RW){1'b0}}, w_qin} << (B + 1))
                       | ({{SW{1'b0}}, 1'b1} << (2 * B));
        assign w_take  = {1'b0, w_rin} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            r_root[k] <= w_take ? (w_qin | ({{(RW-1){1'b0}}, 1'b1} << B)) : w_qin;
        end

        if (k < RW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[k] <= w_take ? (w_rin - w_trial[SW-1:0]) : w_rin;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];

endmodule

@@ design/point_to_line_distance_gate.sv @@
// Point-to-line distance gate: top level with config registers and output stage.
// Uses ptld_pkg, ptld_proj, ptld_norm, ptld_sqrt and the assertion macro header.
// A result strobes after its item passes 5 projection, 2 norm, 24 root-bit stages
// and 1 output stage. Throughput: one item per cycle, busy stays low.
// Reset (synchronous, active low) empties the pipeline and restores register defaults;
// results cannot be held off by the receiver, so nothing ever stalls.
`include "point_to_line_distance_gate_macros.svh"

module point_to_line_distance_gate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [ptld_pkg::CRD_W-1:0]  i_point_x,
    input  logic signed [ptld_pkg::CRD_W-1:0]  i_point_y,
    input  logic signed [ptld_pkg::CRD_W-1:0]  i_point_z,
    input  logic                               i_cfg_we,
    input  logic [ptld_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [ptld_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                               o_valid,
    output logic [ptld_pkg::DIST_W-1:0]        o_distance,
    output logic                               o_accepted
);

    localparam int CW = ptld_pkg::CRD_W;
    localparam int DW = ptld_pkg::DIR_W;
    localparam int RW = ptld_pkg::ROOT_W;
    localparam int TW = ptld_pkg::DIST_W;

    // configuration registers
    ptld_pkg::t_pnt     r_line;
    ptld_pkg::t_dir     r_dir;
    logic [TW-1:0]      r_max;

    // pipeline links
    ptld_pkg::t_pnt     w_pnt;
    logic               w_take;
    logic               w_proj_vld;
    ptld_pkg::t_ortv    w_orth;
    logic               w_norm_vld;
    ptld_pkg::t_sq      w_sq;
    logic               w_root_vld;
    ptld_pkg::t_root    w_root;

    // output stage
    logic               r_o_vld;
    logic [TW-1:0]      r_dist;
    logic               r_acc;
    logic [TW-1:0]      n_dist;

    // every cycle is open for a new item
    assign busy   = 1'b0;
    assign w_take = start && !busy;
    assign w_pnt  = {i_point_x, i_point_y, i_point_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= '0;
            r_dir.x <= '0;
            r_dir.y <= '0;
            r_dir.z <= ptld_pkg::DIR_Z_RST;
            r_max   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptld_pkg::REG_LINE_X: r_line.x <= i_cfg_data[CW-1:0];
                ptld_pkg::REG_LINE_Y: r_line.y <= i_cfg_data[CW-1:0];
                ptld_pkg::REG_LINE_Z: r_line.z <= i_cfg_data[CW-1:0];
                ptld_pkg::REG_DIR_X:  r_dir.x  <= i_cfg_data[DW-1:0];
                ptld_pkg::REG_DIR_Y:  r_dir.y  <= i_cfg_data[DW-1:0];
                ptld_pkg::REG_DIR_Z:  r_dir.z  <= i_cfg_data[DW-1:0];
                ptld_pkg::REG_MAX:    r_max    <= i_cfg_data[TW-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // offset and orthogonal component
    ptld_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_take),
        .i_point (w_pnt),
        .i_line  (r_line),
        .i_dir   (r_dir),
        .o_valid (w_proj_vld),
        .o_orth  (w_orth)
    );

    // squared length
    ptld_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_proj_vld),
        .i_orth  (w_orth),
        .o_valid (w_norm_vld),
        .o_sq    (w_sq)
    );

    // truncating root, one bit per stage
    ptld_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_norm_vld),
        .i_sq    (w_sq),
        .o_valid (w_root_vld),
        .o_root  (w_root)
    );

    // saturate to the field width; anything clipped can never pass the gate
    assign n_dist = (w_root[RW-1:TW] != '0) ? ptld_pkg::DIST_MAX : w_root[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= w_root_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
        r_acc  <= n_dist < r_max;
    end

    assign o_valid    = r_o_vld;
    assign o_distance = r_dist;
    assign o_accepted = r_acc;

    // every item taken comes out as a result, none lost in the pipeline
    `PTLD_ASSERT_IMP(a_item_out, w_take, ##(ptld_pkg::PIPE_LAT) o_valid, "item lost in pipeline")
    // no result without an item taken to match it
    `PTLD_ASSERT_IMP(a_no_ghost, o_valid, $past(w_take, ptld_pkg::PIPE_LAT), "result without item")
    // a zero threshold gates out everything
    `PTLD_ASSERT_NXT(a_zero_gate, w_root_vld && (r_max == '0), !o_accepted, "accepted at zero max")

endmodule

@@ dv/point_to_line_distance_gate_tb.sv @@
// Self-checking testbench for point_to_line_distance_gate: directed and random points,
// checked against a bit-true distance/gate predictor. Depends on ptld_pkg and the RTL.
module point_to_line_distance_gate_tb;

    localparam int     GAP_MAX     = 12;     // longest idle stretch between items
    localparam int     QUIET_LIMIT = 1000;   // watchdog: cycles with no handshake at all
    localparam int     MISS_SHOWN  = 10;     // mismatches printed in full
    localparam longint HALF_LSB    = longint'(1) << (ptld_pkg::RND_SH - 1);
    localparam logic [ptld_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;   // decodes to nothing

    typedef enum {GAPS_NONE, GAPS_FULL, GAPS_SPARSE} t_gap_mode;

    typedef struct packed {
        logic [ptld_pkg::DIST_W-1:0] distance;
        logic                        acc;
    } t_gate_result;

    // Scoreboard: mirrors the registers, predicts each item's result, checks in order.
    class t_gate_scoreboard;
        longint          line_pt[3] = '{0, 0, 0};
        longint          dirv[3]    = '{0, 0, longint'($signed(ptld_pkg::DIR_Z_RST))};
        longint unsigned max_dist   = 0;
        t_gate_result    expected_gates[$];
        int unsigned     mismatches = 0;
        int unsigned     checked    = 0;
        int unsigned     gate_open  = 0;
        int unsigned     saturated  = 0;

        function void write_reg(logic [ptld_pkg::IDX_W-1:0] idx,
                                logic [ptld_pkg::CFG_W-1:0] data);
            case (idx)
                ptld_pkg::REG_LINE_X: line_pt[0] = longint'($signed(data[ptld_pkg::CRD_W-1:0]));
                ptld_pkg::REG_LINE_Y: line_pt[1] = longint'($signed(data[ptld_pkg::CRD_W-1:0]));
                ptld_pkg::REG_LINE_Z: line_pt[2] = longint'($signed(data[ptld_pkg::CRD_W-1:0]));
                ptld_pkg::REG_DIR_X:  dirv[0]    = longint'($signed(data[ptld_pkg::DIR_W-1:0]));
                ptld_pkg::REG_DIR_Y:  dirv[1]    = longint'($signed(data[ptld_pkg::DIR_W-1:0]));
                ptld_pkg::REG_DIR_Z:  dirv[2]    = longint'($signed(data[ptld_pkg::DIR_W-1:0]));
                ptld_pkg::REG_MAX:    max_dist   = data[ptld_pkg::DIST_W-1:0];
                default: ;  // out-of-range index: dropped
            endcase
        endfunction

        // Truncated square root, one result bit at a time from the top.
        function longint unsigned floor_root(longint unsigned n);
            longint unsigned r;
            longint unsigned c;
            int b;
            r = 0;
            for (b = 24; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= n)
                    r = c;
            end
            return r;
        endfunction

        function void note_point(ptld_pkg::t_coord px, ptld_pkg::t_coord py,
                                 ptld_pkg::t_coord pz);
            longint          pnt[3];
            longint          d[3];
            longint          o[3];
            longint          dot;
            longint          t;
            longint          p;
            longint unsigned sq;
            longint unsigned root;
            t_gate_result    e;
            int              k;
            pnt[0] = px;
            pnt[1] = py;
            pnt[2] = pz;
            dot = 0;
            for (k = 0; k < 3; k++) begin
                d[k] = pnt[k] - line_pt[k];
                dot += d[k] * dirv[k];
            end
            // projection length, rounded half up in Q15
            t  = (dot + HALF_LSB) >>> ptld_pkg::RND_SH;
            sq = 0;
            for (k = 0; k < 3; k++) begin
                p    = (t * dirv[k] + HALF_LSB) >>> ptld_pkg::RND_SH;
                o[k] = d[k] - p;
                sq  += o[k] * o[k];
            end
            root = floor_root(sq);
            if (root > ptld_pkg::DIST_MAX)
                root = ptld_pkg::DIST_MAX;
            e.distance = root[ptld_pkg::DIST_W-1:0];
            e.acc      = (root < max_dist);
            expected_gates.push_back(e);
        endfunction

        function void check_result(logic [ptld_pkg::DIST_W-1:0] got_dist, logic acc);
            t_gate_result e;
            checked++;
            if (expected_gates.size() == 0) begin
                mismatches++;
                if (mismatches <= MISS_SHOWN)
                    $display("tb: unexpected result distance %0d accepted %0b", got_dist, acc);
                return;
            end
            e = expected_gates.pop_front();
            if (got_dist !== e.distance || acc !== e.acc) begin
                mismatches++;
                if (mismatches <= MISS_SHOWN)
                    $display("tb: mismatch: distance exp %0d got %0d, accepted exp %0b got %0b",
                             e.distance, got_dist, e.acc, acc);
            end
            if (e.acc)
                gate_open++;
            if (e.distance == ptld_pkg::DIST_MAX)
                saturated++;
        endfunction

        function int pending();
            return expected_gates.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n    = 1'b0;
    logic                          start      = 1'b0;
    logic                          busy;
    ptld_pkg::t_coord              i_point_x  = '0;
    ptld_pkg::t_coord              i_point_y  = '0;
    ptld_pkg::t_coord              i_point_z  = '0;
    logic                          i_cfg_we   = 1'b0;
    logic [ptld_pkg::IDX_W-1:0]    i_cfg_idx  = '0;
    logic [ptld_pkg::CFG_W-1:0]    i_cfg_data = '0;
    logic                          o_valid;
    logic [ptld_pkg::DIST_W-1:0]   o_distance;
    logic                          o_accepted;

    t_gate_scoreboard sb = new;
    t_gap_mode        gap_mode = GAPS_FULL;
    int               settings_used = 0;
    int               quiet_cycles  = 0;

    point_to_line_distance_gate uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_point_z  (i_point_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_distance (o_distance),
        .o_accepted (o_accepted)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitor: everything is sampled as it stood before the edge, same view as the RTL.
    // Register writes are mirrored here so the predictor sees exactly what the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_idx, i_cfg_data);
            if (o_valid)
                sb.check_result(o_distance, o_accepted);
            if (start && !busy)
                sb.note_point(i_point_x, i_point_y, i_point_z);
        end
    end

    // Watchdog: a stall with no item, result or write for this long means a hang.
    // Normal quiet stretches are an idle gap between items or the pipeline draining.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one item after a gap drawn per gap_mode (none in GAPS_NONE) and hold it until taken.
    // start stays high straight into the next item when no gap is drawn.
    task automatic send_point(input ptld_pkg::t_coord px, input ptld_pkg::t_coord py,
                              input ptld_pkg::t_coord pz);
        int gap;
        case (gap_mode)
            GAPS_NONE: gap = 0;
            GAPS_FULL: gap = $urandom_range(0, GAP_MAX);
            default:   gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, GAP_MAX) : 0;
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        i_point_z <= pz;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Stop offering items and wait for every outstanding result.
    // One result per item, so an empty queue means the pipe is empty.
    task automatic drain_pipe();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    // One register write; bits above the register's width carry junk.
    task automatic put_reg(input logic [ptld_pkg::IDX_W-1:0] idx, input longint val,
                           input int width);
        logic [ptld_pkg::CFG_W-1:0] mask;
        logic [ptld_pkg::CFG_W-1:0] data;
        mask       = (ptld_pkg::CFG_W'(1) << width) - 1'b1;
        data       = (ptld_pkg::CFG_W'($urandom) & ~mask) | (ptld_pkg::CFG_W'(val) & mask);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Full register set, written only once the pipe is empty.
    // Ends with a write to an unused index, which must change nothing.
    task automatic load_config(input longint lx, input longint ly, input longint lz,
                               input longint dx, input longint dy, input longint dz,
                               input longint md);
        drain_pipe();
        put_reg(ptld_pkg::REG_LINE_X, lx, ptld_pkg::CRD_W);
        put_reg(ptld_pkg::REG_LINE_Y, ly, ptld_pkg::CRD_W);
        put_reg(ptld_pkg::REG_LINE_Z, lz, ptld_pkg::CRD_W);
        put_reg(ptld_pkg::REG_DIR_X, dx, ptld_pkg::DIR_W);
        put_reg(ptld_pkg::REG_DIR_Y, dy, ptld_pkg::DIR_W);
        put_reg(ptld_pkg::REG_DIR_Z, dz, ptld_pkg::DIR_W);
        put_reg(ptld_pkg::REG_MAX, md, ptld_pkg::DIST_W);
        put_reg(REG_UNUSED, longint'($urandom), ptld_pkg::CFG_W);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        longint lp[3];
        longint dv[3];
        longint md;
        longint s;
        longint along;
        int     off;
        int     k;
        int     n;
        int     ph;
        int     zero_ax;
        ptld_pkg::t_coord pt[3];

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: line along z through the origin, zero threshold, nothing passes.
        send_point('0, '0, '0);
        send_point(20'sd524287, 20'sd524287, 20'sd524287);
        send_point(-20'sd524288, -20'sd524288, -20'sd524288);
        send_point(20'sd3, 20'sd4, 20'sd12);

        // Line along x, threshold 5: exactly 5 is rejected, 4 passes.
        load_config(0, 0, 0, 32767, 0, 0, 5);
        send_point(20'sd1000, 20'sd3, 20'sd4);
        send_point(-20'sd1000, 20'sd0, 20'sd4);
        send_point(20'sd7, -20'sd3, -20'sd3);
        send_point(20'sd0, 20'sd0, 20'sd0);

        // Zero direction: plain distance from the line point, extreme line point.
        load_config(-524288, 524287, -524288, 0, 0, 0, ptld_pkg::DIST_MAX);
        send_point(20'sd524287, -20'sd524288, 20'sd524287);
        send_point(-20'sd524288, 20'sd524287, -20'sd524288);
        send_point('0, '0, '0);

        // Most negative direction: the far corner saturates and never passes; the other points pass.
        load_config(-524288, -524288, -524288, -32768, -32768, -32768, ptld_pkg::DIST_MAX);
        send_point(20'sd524287, 20'sd524287, 20'sd524287);
        send_point(20'sd524287, -20'sd524288, 20'sd0);
        send_point(-20'sd524288, -20'sd524288, -20'sd524288);
        send_point(20'sd1, -20'sd1, 20'sd100);

        // Non-unit diagonal, threshold 1: only a zero distance passes.
        load_config(100, -100, 50, 32767, 32767, 32767, 1);
        send_point(20'sd100, -20'sd100, 20'sd50);
        send_point(20'sd524287, -20'sd524288, 20'sd524287);
        send_point(-20'sd524288, 20'sd524287, -20'sd524288);
        send_point(20'sd101, -20'sd100, 20'sd50);

        // Random settings; most points sit near the line so the gate flips both ways.
        for (ph = 0; ph < 14; ph++) begin
            for (k = 0; k < 3; k++) begin
                if ($urandom_range(0, 1))
                    lp[k] = longint'($urandom_range(0, 8191)) - 4096;
                else
                    lp[k] = ptld_pkg::t_coord'($urandom);
                dv[k] = 0;
            end
            zero_ax = $urandom_range(0, 2);
            case ($urandom_range(0, 5))
                0: dv[zero_ax] = 32767;
                1: begin
                    dv = '{23170, 23170, 23170};
                    dv[zero_ax] = 0;
                end
                2: dv = '{18919, 18919, 18919};
                3: for (k = 0; k < 3; k++) dv[k] = ptld_pkg::t_dirc'($urandom);
                4: begin
                    if ($urandom_range(0, 1))
                        dv = '{-32768, -32768, -32768};
                    else
                        dv = '{32767, 32767, 32767};
                end
                default: ;  // zero direction
            endcase
            if (dv[0] != -32768)
                for (k = 0; k < 3; k++)
                    if ($urandom_range(0, 1))
                        dv[k] = -dv[k];
            case ($urandom_range(0, 5))
                0:       md = 0;
                1:       md = ptld_pkg::DIST_MAX;
                5:       md = $urandom_range(0, ptld_pkg::DIST_MAX);
                default: md = $urandom_range(0, 2500);
            endcase
            load_config(lp[0], lp[1], lp[2], dv[0], dv[1], dv[2], md);
            gap_mode = t_gap_mode'($urandom_range(0, 2));
            for (n = 0; n < 100; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    for (k = 0; k < 3; k++)
                        pt[k] = ptld_pkg::t_coord'($urandom);
                end else begin
                    s = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
                    for (k = 0; k < 3; k++) begin
                        along = (s * dv[k]) >>> ptld_pkg::RND_SH;
                        off   = int'($urandom_range(0, 4000)) - 2000;
                        pt[k] = ptld_pkg::t_coord'(lp[k] + along + off);
                    end
                end
                send_point(pt[0], pt[1], pt[2]);
            end
        end

        drain_pipe();
        repeat (ptld_pkg::PIPE_LAT + 8) @(posedge i_clk);

        $display("tb: %0d results checked over %0d register settings (plus reset defaults)",
                 sb.checked, settings_used);
        $display("tb: %0d passed the gate, %0d saturated, %0d mismatches",
                 sb.gate_open, sb.saturated, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/ptld_pkg.sv
design/ptld_proj.sv
design/ptld_norm.sv
design/ptld_sqrt.sv
design/point_to_line_distance_gate.sv
dv/point_to_line_distance_gate_tb.sv
